// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared widths, character codes, status codes, the alphabet decoder and the
// result group record of the streaming base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int CHAR_W          = 8;
	localparam int BYTE_W          = 8;
	localparam int CFG_W           = 16;
	localparam int TOTAL_W         = 16;
	localparam int ACC_W           = 18;
	localparam int SEXTET_W        = 6;
	localparam int WORD_W          = 24;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam logic [CFG_W-1:0] CFG_RESET = 16'hFFFF;

	// Character codes with a meaning of their own
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D; // '='
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F; // '/'

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_OVF = 2'd2,
		ST_ILL = 2'd3
	} status_t;

	typedef struct packed {
		logic                ok;
		logic [SEXTET_W-1:0] val;
	} sextet_t;

	// One group of results caused by one transaction on the input side
	typedef struct packed {
		logic [WORD_W-1:0]  word;     // bytes, first byte in the top bits
		logic [1:0]         nres;     // number of results, 1 to 3
		logic               is_data;  // byte results rather than a status
		status_t            status;
		logic               eom_last; // last result closes the message
		logic [TOTAL_W-1:0] base;     // bytes emitted before this group
	} grp_t;

	// Map an ASCII code to its 6-bit value; ok is low outside the alphabet
	function automatic sextet_t sextet_decode(input logic [CHAR_W-1:0] c);
		sextet_t           res;
		logic [CHAR_W-1:0] d;
		res = '0;
		d   = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d   = c - 8'h41;
			res = '{ok: 1'b1, val: d[SEXTET_W-1:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d   = c - 8'h61 + 8'd26;
			res = '{ok: 1'b1, val: d[SEXTET_W-1:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d   = c - 8'h30 + 8'd52;
			res = '{ok: 1'b1, val: d[SEXTET_W-1:0]};
		end else if (c == CHAR_PLUS) begin
			res = '{ok: 1'b1, val: 6'd62};
		end else if (c == CHAR_SLASH) begin
			res = '{ok: 1'b1, val: 6'd63};
		end
		return res;
	endfunction

endpackage

// ===== rtl/b64d_char_if.sv =====
// ----------------------------------------------------------------------------
// b64d_char_if
// Character channel: one base64 character and the last-character mark.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	import b64d_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink   (input valid, input text_char, input last_char, output ready);

endinterface

// ===== rtl/b64d_result_if.sv =====
// ----------------------------------------------------------------------------
// b64d_result_if
// Result channel: one decoded byte or one status, with the running count.
// ----------------------------------------------------------------------------
interface b64d_result_if;
	import b64d_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  data_byte;
	logic               byte_valid;
	logic [1:0]         status;
	logic               end_of_message;
	logic [TOTAL_W-1:0] bytes_total;

	modport source (
		output valid, output data_byte, output byte_valid, output status,
		output end_of_message, output bytes_total, input ready
	);
	modport sink (
		input valid, input data_byte, input byte_valid, input status,
		input end_of_message, input bytes_total, output ready
	);

endinterface

// ===== rtl/base64_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder with padding checks, length and capacity status.
// ----------------------------------------------------------------------------
// Accepts one character per clock cycle while the result buffer has room. Each
// character is held in an input register and then decoded against the quartet
// state in a single pass; a quartet that completes writes its bytes as one
// group into a two-group result buffer, from which results leave one per cycle
// while the sink is ready. A full quartet gives three results while the next
// three characters give none, so a stream of valid text runs at one character
// per cycle when the result side never holds off. A character passes the input
// register and the result buffer before its group's first result appears.
// Input stalls only while both result groups are occupied: when the result side
// holds off, when a status result follows straight after a full quartet, or
// when a burst of status results meets a slow sink. The user must write max_q
// through cfg_we/cfg_wdata only between messages; the block does not enforce it.
module base64_stream_decoder_top #(
	parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [b64d_pkg::CFG_W-1:0]  cfg_wdata,
	b64d_char_if.sink                   chars,
	b64d_result_if.source               results
);
	import b64d_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH + 1 > CFG_W + 1) ? COUNT_WIDTH + 1 : CFG_W + 1;

	// Configuration register
	logic [CFG_W-1:0] max_q;

	// Input stage
	logic              vld_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// Message state
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic [1:0]             pos_q, pos_d;
	logic [1:0]             pad_q, pad_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                   skip_q, skip_d;

	// Result group buffer
	grp_t       grp_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] grp_cnt_q;
	logic [1:0] idx_q;
	grp_t       head;
	grp_t       grp_d;
	logic       push, pop, last_res;

	logic    adv;
	sextet_t sx;
	logic    is_nul, is_pad, ill, ovf, fin;
	status_t fin_st;
	logic [1:0]          pad_n, nbytes;
	logic [SEXTET_W-1:0] val;
	logic [CMP_W-1:0]    cnt_ext, newcount;
	logic [WORD_W-1:0]   word, shifted;

	// Take a character whenever the input stage drains or is empty
	assign adv         = vld_s1 && (grp_cnt_q != 2'd2);
	assign chars.ready = !vld_s1 || (grp_cnt_q != 2'd2);

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= CFG_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Advance the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.text_char;
			last_s1 <= chars.last_char;
		end
	end

	// Classify the held character
	assign sx       = sextet_decode(char_s1);
	assign is_nul   = (char_s1 == CHAR_NUL);
	assign is_pad   = (char_s1 == CHAR_PAD);
	assign ill      = ((pad_q != 2'd0) && (pos_q == 2'd0)) ||
	                  (is_pad && (pos_q < 2'd2)) ||
	                  (!is_pad && (!sx.ok || (pad_q != 2'd0)));
	assign pad_n    = is_pad ? pad_q + 2'd1 : pad_q;
	assign val      = is_pad ? '0 : sx.val;
	assign word     = {acc_q, val};
	assign nbytes   = 2'd3 - pad_n;
	assign cnt_ext  = CMP_W'(cnt_q);
	assign newcount = cnt_ext + CMP_W'(nbytes);
	assign ovf      = (newcount > CMP_W'(max_q)) || newcount[COUNT_WIDTH];

	// Work out the next quartet state and the result group to store
	always_comb begin
		acc_d  = acc_q;
		pos_d  = pos_q;
		pad_d  = pad_q;
		cnt_d  = cnt_q;
		skip_d = skip_q;
		push   = 1'b0;
		grp_d  = '0;
		fin    = 1'b0;
		fin_st = ST_OK;
		if (adv) begin
			if (skip_q) begin
				if (last_s1) begin
					skip_d = 1'b0;
					acc_d  = '0;
					pos_d  = '0;
					pad_d  = '0;
					cnt_d  = '0;
				end
			end else if (is_nul) begin
				fin    = 1'b1;
				fin_st = (pos_q != 2'd0) ? ST_LEN : ST_OK;
			end else if (ill) begin
				fin    = 1'b1;
				fin_st = ST_ILL;
			end else if (pos_q != 2'd3) begin
				acc_d = {acc_q[ACC_W-SEXTET_W-1:0], val};
				pos_d = pos_q + 2'd1;
				pad_d = pad_n;
				if (last_s1) begin
					fin    = 1'b1;
					fin_st = ST_LEN;
				end
			end else if (ovf) begin
				fin    = 1'b1;
				fin_st = ST_OVF;
			end else begin
				push  = 1'b1;
				grp_d = '{word: word, nres: nbytes, is_data: 1'b1, status: ST_OK,
				          eom_last: last_s1, base: cnt_ext[TOTAL_W-1:0]};
				cnt_d = newcount[COUNT_WIDTH-1:0];
				acc_d = '0;
				pos_d = '0;
				pad_d = pad_n;
				if (last_s1) begin
					cnt_d = '0;
					pad_d = '0;
				end
			end
			// Close the message with one status result
			if (fin) begin
				push   = 1'b1;
				grp_d  = '{word: '0, nres: 2'd1, is_data: 1'b0, status: fin_st,
				           eom_last: 1'b1, base: cnt_ext[TOTAL_W-1:0]};
				acc_d  = '0;
				pos_d  = '0;
				pad_d  = '0;
				cnt_d  = '0;
				skip_d = !last_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			pad_q  <= '0;
			cnt_q  <= '0;
			skip_q <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			pos_q  <= pos_d;
			pad_q  <= pad_d;
			cnt_q  <= cnt_d;
			skip_q <= skip_d;
		end
	end

	// Store result groups
	always_ff @(posedge clk) begin
		if (push) begin
			grp_q[wr_ptr_q] <= grp_d;
		end
	end

	assign head     = grp_q[rd_ptr_q];
	assign last_res = (idx_q == head.nres - 2'd1);
	assign pop      = results.valid && results.ready;

	// Step through the head group, then release it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			grp_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				if (last_res) begin
					idx_q    <= '0;
					rd_ptr_q <= !rd_ptr_q;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			grp_cnt_q <= grp_cnt_q + 2'(push) - 2'(pop && last_res);
		end
	end

	// Drive the result channel from the head group
	assign shifted                = word_shift(head.word, idx_q);
	assign results.valid          = (grp_cnt_q != 2'd0);
	assign results.data_byte      = shifted[WORD_W-1 -: BYTE_W];
	assign results.byte_valid     = head.is_data;
	assign results.status         = head.status;
	assign results.end_of_message = head.eom_last && last_res;
	assign results.bytes_total    = head.is_data ?
	                                head.base + TOTAL_W'(idx_q) + TOTAL_W'(1) : head.base;

	function automatic logic [WORD_W-1:0] word_shift(input logic [WORD_W-1:0] w,
	                                                input logic [1:0] i);
		logic [WORD_W-1:0] r;
		r = w;
		case (i)
			2'd1:    r = {w[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
			2'd2:    r = {w[BYTE_W-1:0], {(WORD_W-BYTE_W){1'b0}}};
			default: r = w;
		endcase
		return r;
	endfunction

`ifndef NO_ASSERTIONS
	a_grp_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		grp_cnt_q <= 2'd2)
		else $error("result group count above buffer depth");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_cnt_q != 2'd0) |-> (idx_q < head.nres))
		else $error("result index beyond its group");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && skip_q) |-> !push)
		else $error("result stored while skipping to the end mark");

	a_quartet_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(push && grp_d.is_data) |=> (pos_q == 2'd0) && (acc_q == '0))
		else $error("quartet state left over after emitting bytes");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming base64 decoder. Character
// transactions are predicted on acceptance by a scoreboard that keeps its own
// quartet state and capacity. Every result transaction is compared field by
// field against the oldest prediction. Stimulus is a short directed set, then
// random messages: mostly well-formed, the rest truncated, broken or noisy.
// The run steps through several capacities and flow-control mixes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_CYCLES    = 60;
	localparam int TAIL_CYCLES    = 10;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic               byte_valid;
		status_t            status;
		logic               end_of_message;
		logic [TOTAL_W-1:0] bytes_total;
	} decoded_t;

	// Scoreboard: predicts decoded bytes and statuses, holds them in order
	class decode_scoreboard;
		logic [ACC_W-1:0]   acc;
		logic [1:0]         quartet_pos;
		logic [1:0]         pad_count;
		logic [TOTAL_W-1:0] out_count;
		bit                 skipping;
		logic [CFG_W-1:0]   capacity;
		decoded_t           expected_q[$];
		int                 chars_seen;
		int                 chars_decoded;
		int                 results_checked;
		int                 messages;
		int                 mismatches;
		int                 status_hits[4];

		function new();
			capacity = CFG_RESET;
			skipping = 1'b0;
			clear_message();
		endfunction

		function void clear_message();
			acc         = '0;
			quartet_pos = '0;
			pad_count   = '0;
			out_count   = '0;
		endfunction

		function void set_capacity(input logic [CFG_W-1:0] v);
			capacity = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Close the message with one status transaction; skip to the mark unless here
		function void close_message(input status_t st, input bit last);
			decoded_t r;
			r.data_byte      = '0;
			r.byte_valid     = 1'b0;
			r.status         = st;
			r.end_of_message = 1'b1;
			r.bytes_total    = out_count;
			expected_q.push_back(r);
			clear_message();
			skipping = !last;
		endfunction

		// Alphabet lookup: upper case, lower case, digits, plus and slash
		function bit alphabet_value(input logic [CHAR_W-1:0] c,
					    output logic [SEXTET_W-1:0] v);
			logic [CHAR_W-1:0] d;
			d = '0;
			v = '0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				d = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				d = c - 8'h61 + 8'd26;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30 + 8'd52;
			end else if (c == CHAR_PLUS) begin
				d = 8'd62;
			end else if (c == CHAR_SLASH) begin
				d = 8'd63;
			end else begin
				return 1'b0;
			end
			v = d[SEXTET_W-1:0];
			return 1'b1;
		endfunction

		// Note one accepted character; returns 1 unless it was skipped
		function bit note_char(input logic [CHAR_W-1:0] c, input bit last);
			logic [SEXTET_W-1:0] val;
			logic [WORD_W-1:0]   word;
			logic [TOTAL_W:0]    new_count;
			int                  n;
			decoded_t            r;
			chars_seen++;
			if (skipping) begin
				if (last) begin
					skipping = 1'b0;
					clear_message();
				end
				return 1'b0;
			end
			chars_decoded++;
			if (c == CHAR_NUL) begin
				close_message(quartet_pos != 0 ? ST_LEN : ST_OK, last);
				return 1'b1;
			end
			// Nothing may follow a padded quartet
			if (pad_count != 0 && quartet_pos == 0) begin
				close_message(ST_ILL, last);
				return 1'b1;
			end
			if (c == CHAR_PAD) begin
				if (quartet_pos < 2) begin
					close_message(ST_ILL, last);
					return 1'b1;
				end
				pad_count = pad_count + 2'd1;
				val       = '0;
			end else if (!alphabet_value(c, val) || pad_count != 0) begin
				close_message(ST_ILL, last);
				return 1'b1;
			end
			if (quartet_pos < 3) begin
				acc         = {acc[ACC_W-SEXTET_W-1:0], val};
				quartet_pos = quartet_pos + 2'd1;
				if (last)
					close_message(ST_LEN, 1'b1);
				return 1'b1;
			end
			// Quartet complete: check capacity, then emit its bytes
			word      = {acc, val};
			n         = 3 - pad_count;
			new_count = (TOTAL_W+1)'(out_count + n);
			if (new_count > capacity) begin
				close_message(ST_OVF, last);
				return 1'b1;
			end
			acc         = '0;
			quartet_pos = '0;
			for (int i = 0; i < n; i++) begin
				out_count        = out_count + 1'b1;
				r.data_byte      = word[WORD_W-1-8*i -: 8];
				r.byte_valid     = 1'b1;
				r.status         = ST_OK;
				r.end_of_message = last && (i == n - 1);
				r.bytes_total    = out_count;
				expected_q.push_back(r);
			end
			if (last) begin
				clear_message();
				skipping = 1'b0;
			end
			return 1'b1;
		endfunction

		// Compare one result transaction with the oldest prediction
		function void check_result(input decoded_t got);
			decoded_t want;
			results_checked++;
			if (!$isunknown(got.status))
				status_hits[got.status]++;
			if (got.end_of_message === 1'b1)
				messages++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing predicted: ", $time,
						 "data %h valid %b status %0d eom %b total %0d",
						 got.data_byte, got.byte_valid, got.status,
						 got.end_of_message, got.bytes_total);
				return;
			end
			want = expected_q.pop_front();
			if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
			    got.status !== want.status || got.end_of_message !== want.end_of_message ||
			    got.bytes_total !== want.bytes_total) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result wrong: ", $time,
						 "want data %h valid %b status %0d eom %b total %0d, ",
						 want.data_byte, want.byte_valid, want.status,
						 want.end_of_message, want.bytes_total,
						 "got data %h valid %b status %0d eom %b total %0d",
						 got.data_byte, got.byte_valid, got.status,
						 got.end_of_message, got.bytes_total);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	b64d_char_if   chars_if ();
	b64d_result_if results_if ();

	decode_scoreboard sb;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	base64_stream_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars_if),
		.results   (results_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Note each accepted character transaction
	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready)
			void'(sb.note_char(chars_if.text_char, chars_if.last_char));
	end

	// Check each accepted result transaction
	always @(posedge clk) begin
		decoded_t got;
		if (arst_n && results_if.valid && results_if.ready) begin
			got.data_byte      = results_if.data_byte;
			got.byte_valid     = results_if.byte_valid;
			got.status         = status_t'(results_if.status);
			got.end_of_message = results_if.end_of_message;
			got.bytes_total    = results_if.bytes_total;
			sb.check_result(got);
		end
	end

	// Result sink: random stalls, plus a long hold-off on request
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			 WATCHDOG_LIMIT, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] alphabet_char(input int idx);
		if (idx < 26)
			return CHAR_W'(8'h41 + idx);
		else if (idx < 52)
			return CHAR_W'(8'h61 + idx - 26);
		else if (idx < 62)
			return CHAR_W'(8'h30 + idx - 52);
		else if (idx == 62)
			return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	// Offer one character, with random idle cycles first; hold until taken
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.text_char <= c;
		chars_if.last_char <= last;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s, input bit mark_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], mark_last && (i == s.len() - 1));
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic drain_results();
		chars_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Write the capacity only once the block has gone quiet
	task automatic write_capacity(input logic [CFG_W-1:0] v);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
	endtask

	// One random message: mostly well-formed, sometimes truncated or corrupted
	task automatic send_random_message();
		logic [CHAR_W-1:0] msg[$];
		int                nq;
		int                pads;
		int                kind;
		int                pos;
		nq = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
		for (int q = 0; q < nq; q++)
			for (int k = 0; k < 4; k++)
				msg.push_back(alphabet_char($urandom_range(63)));
		pads = $urandom_range(3);
		if (nq > 0 && pads == 1) begin
			msg[msg.size()-1] = CHAR_PAD;
		end else if (nq > 0 && pads == 2) begin
			msg[msg.size()-1] = CHAR_PAD;
			msg[msg.size()-2] = CHAR_PAD;
		end
		kind = $urandom_range(99);
		pos  = (msg.size() > 0) ? $urandom_range(msg.size() - 1) : 0;
		if (kind >= 70 && kind < 76) begin
			repeat ($urandom_range(1, 3))
				if (msg.size() > 0)
					void'(msg.pop_back());
		end else if (kind >= 76 && kind < 84 && msg.size() > 0) begin
			msg[pos] = CHAR_W'($urandom_range(255));
		end else if (kind >= 84 && kind < 88 && msg.size() > 0) begin
			msg[pos] = CHAR_PAD;
		end else if (kind >= 88 && kind < 93 && msg.size() > 0) begin
			msg[pos] = CHAR_NUL;
		end else if (kind >= 93) begin
			msg.push_back(alphabet_char($urandom_range(63)));
		end
		// End the text early with a NUL now and then, trailing noise after it
		if ($urandom_range(4) == 0) begin
			msg.push_back(CHAR_NUL);
			repeat ($urandom_range(2))
				msg.push_back(CHAR_W'($urandom_range(255)));
		end
		if (msg.size() == 0)
			msg.push_back(CHAR_NUL);
		for (int i = 0; i < msg.size(); i++)
			send_char(msg[i], i == msg.size() - 1);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] cap, input int send_pct,
				 input int recv_pct, input int items, input bit pause_mid,
				 input bit hold_off);
		int start;
		bit paused;
		paused = 1'b0;
		write_capacity(cap);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		if (hold_off)
			hold_asked++;
		start = sb.chars_seen;
		while (sb.chars_seen - start < items) begin
			send_random_message();
			if (pause_mid && !paused && sb.chars_seen - start >= items / 2) begin
				paused = 1'b1;
				drain_results();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		chars_if.valid     <= 1'b0;
		chars_if.text_char <= '0;
		chars_if.last_char <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full and padded quartets, empty text, NUL, bad characters
		send_text("TWFu", 1'b1);
		send_text("+/z=", 1'b1);
		send_text("TQ==", 1'b0);
		send_text("A", 1'b1);
		send_char(CHAR_NUL, 1'b1);
		send_text("T", 1'b0);
		send_char(CHAR_NUL, 1'b0);
		send_text("A", 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("T=", 1'b1);
		send_text("TWF", 1'b1);
		write_capacity('0);
		send_text("AAAA", 1'b1);

		// Random phases over capacities and flow-control mixes
		run_phase(16'd0, 79, 0, 12, 1'b0, 1'b0);
		run_phase(16'hFFFF, 0, 79, 20, 1'b1, 1'b0);
		run_phase(16'd7, 29, 29, 20, 1'b0, 1'b0);
		run_phase(CFG_W'($urandom_range(1, 30)), 0, 0, 20, 1'b0, 1'b1);
		run_phase(CFG_W'($urandom_range(4, 12)), 29, 29, 15, 1'b0, 1'b0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d characters (%0d decoded, %0d skipped) ",
			 sb.chars_seen, sb.chars_decoded, sb.chars_seen - sb.chars_decoded,
			 "at capacities from 0 to 65535.");
		$display("Checked %0d results over %0d messages: ",
			 sb.results_checked, sb.messages,
			 "%0d ok, %0d length, %0d overflow, %0d illegal.",
			 sb.status_hits[ST_OK], sb.status_hits[ST_LEN],
			 sb.status_hits[ST_OVF], sb.status_hits[ST_ILL]);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches in total", sb.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/b64d_char_if.sv
rtl/b64d_result_if.sv
rtl/base64_stream_decoder_top.sv
test/testbench.sv
